[rtl/edf_pkg.sv]
// Shared types and event codes for the deadline task table.
package edf_pkg;

    // Request codes carried on the input transaction.
    localparam logic [1:0] REQ_CREATE   = 2'd0;
    localparam logic [1:0] REQ_COMPLETE = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;

    // Event codes of a result transaction.
    localparam logic [2:0] EV_EXPIRED  = 3'd0;
    localparam logic [2:0] EV_CREATED  = 3'd1;
    localparam logic [2:0] EV_REJECTED = 3'd2;
    localparam logic [2:0] EV_COMPLETE = 3'd3;
    localparam logic [2:0] EV_NOTFOUND = 3'd4;
    localparam logic [2:0] EV_TICKDONE = 3'd5;

    // One table entry as it moves between cells.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] deadline;
        logic [31:0] release_tick;
    } t_entry;

    // Row command broadcast to every cell.
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_SHIFT_UP,
        CMD_SHIFT_DOWN
    } t_cmd;

    // Control word sent from the sequencer to the cell row.
    typedef struct packed {
        t_cmd       cmd;
        logic [8:0] pos;
        t_entry     ins;
    } t_row_ctl;

endpackage

[rtl/edf_cell.sv]
// One table cell: holds one entry and trades it with its neighbors.
module edf_cell #(
    parameter int IDX_W = 4,
    parameter logic [IDX_W-1:0] MY_IDX = '0
) (
    input  logic            i_clk,
    input  edf_pkg::t_row_ctl i_ctl,
    input  edf_pkg::t_entry i_from_up,
    input  edf_pkg::t_entry i_from_down,
    output edf_pkg::t_entry o_entry
);
    import edf_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_at_pos;
    logic   w_after_pos;

    // Compare this cell's place with the operation position.
    assign w_at_pos    = ({1'b0, i_ctl.pos} == 10'(MY_IDX));
    assign w_after_pos = (10'(MY_IDX) > {1'b0, i_ctl.pos});

    // Insert opens a gap at pos; remove closes the gap at pos.
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            CMD_SHIFT_UP: begin
                if (w_at_pos) begin
                    n_entry = i_ctl.ins;
                end else if (w_after_pos) begin
                    n_entry = i_from_down;
                end
            end
            CMD_SHIFT_DOWN: begin
                if (w_at_pos || w_after_pos) begin
                    n_entry = i_from_up;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule

[rtl/edf_row.sv]
// Row of table cells linked to their neighbors.
module edf_row #(
    parameter int MAX_TASKS = 16,
    parameter int IDX_W = 4
) (
    input  logic                i_clk,
    input  edf_pkg::t_row_ctl   i_ctl,
    output edf_pkg::t_entry     o_entries [MAX_TASKS]
);
    import edf_pkg::*;

    t_entry w_ent [MAX_TASKS];

    // Each cell sees the entry below (lower index) and above (higher index).
    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        t_entry w_dn;
        t_entry w_up;
        if (g == 0) begin : g_first
            assign w_dn = w_ent[0];
        end else begin : g_mid
            assign w_dn = w_ent[g-1];
        end
        if (g == MAX_TASKS-1) begin : g_last
            assign w_up = w_ent[g];
        end else begin : g_nxt
            assign w_up = w_ent[g+1];
        end
        edf_cell #(
            .IDX_W  (IDX_W),
            .MY_IDX (IDX_W'(g))
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_from_up   (w_up),
            .i_from_down (w_dn),
            .o_entry     (w_ent[g])
        );
        assign o_entries[g] = w_ent[g];
    end
endmodule

[rtl/edf_deadline_task_table.sv]
// Top level of the earliest-deadline-first task table: sequencer, cell row, overdue count.
// An input transaction first registers the tick time product once at the start, then
// expires overdue tasks from the head, each with its own result, and then scans the table.
// The scan examines one table position per cycle while the output register is free; a
// create stops at its insert position, a complete at the matching position or after the
// last entry when no match is found; a tick and a create on a full table give their result
// without a search. A result that waits in the output register without being taken holds
// the sequence back. The cell row shifts all entries together to insert or remove. Results
// leave through an output register; the next transaction is taken once the final result
// of the current one has been handed over.
module edf_deadline_task_table #(
    parameter int MAX_TASKS    = 16,
    parameter int OVERDUE_KEEP = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_task_id,
    input  logic [31:0] i_deadline_ms,
    input  logic [31:0] i_now_tick,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [31:0] o_out_task_id,
    output logic [31:0] o_out_deadline_ms,
    output logic [31:0] o_out_release_tick,
    output logic [4:0]  o_active_used,
    output logic [2:0]  o_overdue_used,
    output logic        o_last_result
);
    import edf_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int OVD_W = $clog2(OVERDUE_KEEP + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TIME,
        ST_EXPIRE,
        ST_SCAN,
        ST_EMIT,
        ST_EXP_OUT
    } t_state;

    t_state           r_state;
    logic [9:0]       r_period;
    logic [1:0]       r_req;
    logic [31:0]      r_id;
    logic [31:0]      r_dl;
    logic [31:0]      r_now;
    logic [31:0]      r_time;
    logic [CNT_W-1:0] r_count;
    logic [OVD_W-1:0] r_ovd;
    logic [CNT_W-1:0] r_pos;
    logic             r_valid;
    logic [2:0]       r_kind;
    logic [31:0]      r_oid;
    logic [31:0]      r_odl;
    logic [31:0]      r_orel;
    logic             r_last;
    t_row_ctl         w_ctl;
    t_entry           w_ent [MAX_TASKS];
    t_entry           w_cur;
    t_entry           w_head;
    logic             w_out_free;

    assign w_head     = w_ent[0];
    assign w_cur      = w_ent[r_pos[IDX_W-1:0]];
    assign w_out_free = !r_valid || i_ready;
    assign o_ready    = (r_state == ST_IDLE) && w_out_free;

    // Row command comes from the sequencer state and current position.
    always_comb begin
        w_ctl.cmd = CMD_HOLD;
        w_ctl.pos = 9'(r_pos);
        w_ctl.ins.id = r_id;
        w_ctl.ins.deadline = r_dl;
        w_ctl.ins.release_tick = r_now;
        if (r_state == ST_EXPIRE && w_out_free && r_count != '0
            && w_head.deadline <= r_time) begin
            w_ctl.cmd = CMD_SHIFT_DOWN;
            w_ctl.pos = '0;
        end else if (r_state == ST_SCAN && w_out_free) begin
            if (r_req == REQ_CREATE && r_count < CNT_W'(MAX_TASKS)
                && (r_pos == r_count || w_cur.deadline > r_dl)) begin
                w_ctl.cmd = CMD_SHIFT_UP;
            end else if (r_req == REQ_COMPLETE && r_pos != r_count
                         && w_cur.id == r_id) begin
                w_ctl.cmd = CMD_SHIFT_DOWN;
            end
        end
    end

    edf_row #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W)
    ) u_row (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .o_entries (w_ent)
    );

    // Sequencer: time product, head expiry, then one scan for the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_period <= 10'd1;
            r_count  <= '0;
            r_ovd    <= '0;
            r_valid  <= 1'b0;
            r_pos    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req   <= i_req_type;
                        r_id    <= i_task_id;
                        r_dl    <= i_deadline_ms;
                        r_now   <= i_now_tick;
                        r_state <= ST_TIME;
                    end
                end
                ST_TIME: begin
                    r_time  <= 32'(r_now * {22'd0, r_period});
                    r_state <= ST_EXPIRE;
                end
                ST_EXPIRE: begin
                    if (w_out_free) begin
                        if (w_ctl.cmd == CMD_SHIFT_DOWN) begin
                            r_count <= r_count - 1'b1;
                            if (r_ovd != OVD_W'(OVERDUE_KEEP)) begin
                                r_ovd <= r_ovd + 1'b1;
                            end
                            r_kind  <= EV_EXPIRED;
                            r_oid   <= w_head.id;
                            r_odl   <= w_head.deadline;
                            r_orel  <= w_head.release_tick;
                            r_last  <= 1'b0;
                            r_state <= ST_EXP_OUT;
                        end else begin
                            r_pos   <= '0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_EXP_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= ST_EXPIRE;
                end
                ST_SCAN: begin
                    if (w_out_free) begin
                        r_last <= 1'b1;
                        if (r_req == REQ_CREATE) begin
                            r_oid  <= r_id;
                            r_odl  <= r_dl;
                            r_orel <= r_now;
                            if (r_count == CNT_W'(MAX_TASKS)) begin
                                r_kind  <= EV_REJECTED;
                                r_state <= ST_EMIT;
                            end else if (w_ctl.cmd == CMD_SHIFT_UP) begin
                                r_kind  <= EV_CREATED;
                                r_count <= r_count + 1'b1;
                                r_state <= ST_EMIT;
                            end else begin
                                r_pos <= r_pos + 1'b1;
                            end
                        end else if (r_req == REQ_COMPLETE) begin
                            r_oid <= r_id;
                            if (r_pos == r_count) begin
                                r_kind  <= EV_NOTFOUND;
                                r_odl   <= '0;
                                r_orel  <= '0;
                                r_state <= ST_EMIT;
                            end else if (w_ctl.cmd == CMD_SHIFT_DOWN) begin
                                r_kind  <= EV_COMPLETE;
                                r_odl   <= w_cur.deadline;
                                r_orel  <= w_cur.release_tick;
                                r_count <= r_count - 1'b1;
                                r_state <= ST_EMIT;
                            end else begin
                                r_pos <= r_pos + 1'b1;
                            end
                        end else begin
                            r_kind  <= EV_TICKDONE;
                            r_oid   <= '0;
                            r_odl   <= '0;
                            r_orel  <= '0;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register; counts are taken after the event was applied.
    assign o_valid            = r_valid;
    assign o_event_kind       = r_kind;
    assign o_out_task_id      = r_oid;
    assign o_out_deadline_ms  = r_odl;
    assign o_out_release_tick = r_orel;
    assign o_active_used      = 5'(r_count);
    assign o_overdue_used     = 3'(r_ovd);
    assign o_last_result      = r_last;

    // The active count never exceeds the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TASKS))
        else $error("active count beyond table depth");

    // The overdue count saturates at the kept depth.
    a_ovd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovd <= OVD_W'(OVERDUE_KEEP))
        else $error("overdue count beyond kept depth");

    // An expiry result is never marked as the final result.
    a_exp_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == EV_EXPIRED) |-> !o_last_result)
        else $error("expiry marked final");

    // Acceptance of a new transaction starts the sequence at the time product state.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_TIME))
        else $error("accept did not start sequence");
endmodule

[test/edf_deadline_task_table_tb.sv]
// Self-checking testbench for the deadline-ordered task table.
`timescale 1ns / 100ps

module edf_deadline_task_table_tb;
    import edf_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int OVERDUE_SIZE = 5;
    localparam int CYCLE_LIMIT  = 400000;

    // Expected result of one event.
    typedef struct {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] deadline;
        logic [31:0] release_tick;
        logic [4:0]  active_used;
        logic [2:0]  overdue_used;
        logic        last;
    } t_event;

    // Scoreboard: mirrors the task table and holds the pending events.
    class task_table_scoreboard;
        logic [31:0] ids[TABLE_DEPTH];
        logic [31:0] deadlines[TABLE_DEPTH];
        logic [31:0] releases[TABLE_DEPTH];
        int          task_count;
        int          overdue_count;
        logic [9:0]  period;
        t_event      pending_events[$];
        int          mismatches;

        function new();
            task_count    = 0;
            overdue_count = 0;
            period        = 10'd1;
            mismatches    = 0;
        endfunction

        function void queue_event(logic [2:0] kind, logic [31:0] id, logic [31:0] dl,
                                  logic [31:0] rel, logic last);
            t_event ev;
            ev.kind         = kind;
            ev.id           = id;
            ev.deadline     = dl;
            ev.release_tick = rel;
            ev.active_used  = 5'(task_count);
            ev.overdue_used = 3'(overdue_count);
            ev.last         = last;
            pending_events.push_back(ev);
        endfunction

        function void drop_entry(int pos);
            for (int i = pos; i + 1 < task_count; i++) begin
                ids[i]       = ids[i + 1];
                deadlines[i] = deadlines[i + 1];
                releases[i]  = releases[i + 1];
            end
            task_count--;
        endfunction

        // Note one accepted request and predict its events.
        function void note_request(logic [1:0] req, logic [31:0] id, logic [31:0] dl,
                                   logic [31:0] now);
            logic [63:0] product;
            logic [31:0] now_ms;
            logic [31:0] eid, edl, erel;
            int          pos;
            product = 64'(now) * 64'(period);
            now_ms  = product[31:0];
            // Expire overdue tasks from the head first.
            while (task_count > 0 && deadlines[0] <= now_ms) begin
                eid  = ids[0];
                edl  = deadlines[0];
                erel = releases[0];
                drop_entry(0);
                if (overdue_count < OVERDUE_SIZE) overdue_count++;
                queue_event(EV_EXPIRED, eid, edl, erel, 1'b0);
            end
            if (req == REQ_CREATE) begin
                if (task_count >= TABLE_DEPTH) begin
                    queue_event(EV_REJECTED, id, dl, now, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < task_count && deadlines[pos] <= dl) pos++;
                    for (int i = task_count; i > pos; i--) begin
                        ids[i]       = ids[i - 1];
                        deadlines[i] = deadlines[i - 1];
                        releases[i]  = releases[i - 1];
                    end
                    ids[pos]       = id;
                    deadlines[pos] = dl;
                    releases[pos]  = now;
                    task_count++;
                    queue_event(EV_CREATED, id, dl, now, 1'b1);
                end
            end else if (req == REQ_COMPLETE) begin
                pos = 0;
                while (pos < task_count && ids[pos] != id) pos++;
                if (pos < task_count) begin
                    edl  = deadlines[pos];
                    erel = releases[pos];
                    drop_entry(pos);
                    queue_event(EV_COMPLETE, id, edl, erel, 1'b1);
                end else begin
                    queue_event(EV_NOTFOUND, id, 32'd0, 32'd0, 1'b1);
                end
            end else begin
                queue_event(EV_TICKDONE, 32'd0, 32'd0, 32'd0, 1'b1);
            end
        endfunction

        // Compare one accepted result with the oldest pending event.
        function void check_result(t_event got);
            t_event want;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d id=%h", got.kind, got.id);
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind || got.id !== want.id ||
                got.deadline !== want.deadline || got.release_tick !== want.release_tick ||
                got.active_used !== want.active_used ||
                got.overdue_used !== want.overdue_used || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: expected kind=%0d id=%h dl=%h rel=%h act=%0d ovd=%0d last=%0d",
                             want.kind, want.id, want.deadline, want.release_tick,
                             want.active_used, want.overdue_used, want.last);
                    $display("       actual   kind=%0d id=%h dl=%h rel=%h act=%0d ovd=%0d last=%0d",
                             got.kind, got.id, got.deadline, got.release_tick,
                             got.active_used, got.overdue_used, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [9:0]  i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_task_id = '0;
    logic [31:0] i_deadline_ms = '0;
    logic [31:0] i_now_tick = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_event_kind;
    logic [31:0] o_out_task_id;
    logic [31:0] o_out_deadline_ms;
    logic [31:0] o_out_release_tick;
    logic [4:0]  o_active_used;
    logic [2:0]  o_overdue_used;
    logic        o_last_result;

    task_table_scoreboard scoreboard = new();
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  cycle_count    = 0;
    logic [31:0] tick_now = '0;
    logic [31:0] id_pool[8];

    // Clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    edf_deadline_task_table DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_task_id          (i_task_id),
        .i_deadline_ms      (i_deadline_ms),
        .i_now_tick         (i_now_tick),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_event_kind       (o_event_kind),
        .o_out_task_id      (o_out_task_id),
        .o_out_deadline_ms  (o_out_deadline_ms),
        .o_out_release_tick (o_out_release_tick),
        .o_active_used      (o_active_used),
        .o_overdue_used     (o_overdue_used),
        .o_last_result      (o_last_result)
    );

    // Receiver: random stalls, result check on each accepted transaction.
    always @(posedge i_clk) begin
        t_event got;
        if (i_rst_n && o_valid && i_ready) begin
            got.kind         = o_event_kind;
            got.id           = o_out_task_id;
            got.deadline     = o_out_deadline_ms;
            got.release_tick = o_out_release_tick;
            got.active_used  = o_active_used;
            got.overdue_used = o_overdue_used;
            got.last         = o_last_result;
            scoreboard.check_result(got);
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Send one request and wait until it is taken; valid drops only when the sender idles or drains.
    task automatic send_request(logic [1:0] req, logic [31:0] id, logic [31:0] dl,
                                logic [31:0] now);
        bit idling;
        idling = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            if (!idling) i_valid <= 1'b0;
            idling = 1'b1;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_task_id     <= id;
        i_deadline_ms <= dl;
        i_now_tick    <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        scoreboard.note_request(req, id, dl, now);
    endtask

    // Wait until every event has arrived, then let the block settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (scoreboard.pending_events.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_period(logic [9:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        scoreboard.period = value;
    endtask

    // Random request with time moving slowly forward; mostly well-formed traffic.
    task automatic send_random_request();
        int          sel;
        logic [1:0]  req;
        logic [31:0] id, dl, now_ms;
        logic [63:0] product;
        sel = $urandom_range(99);
        if ($urandom_range(3) == 0) tick_now = tick_now + $urandom_range(3);
        product = 64'(tick_now) * 64'(scoreboard.period);
        now_ms  = product[31:0];
        id      = ($urandom_range(3) == 0) ? $urandom() : id_pool[$urandom_range(7)];
        if ($urandom_range(19) == 0) dl = $urandom();
        else dl = now_ms + $urandom_range(60 * (scoreboard.period + 1));
        if (sel < 50) req = REQ_CREATE;
        else if (sel < 80) req = REQ_COMPLETE;
        else if (sel < 95) req = REQ_TICK;
        else req = 2'd3;
        if (sel < 5) tick_now = $urandom();
        send_request(req, id, dl, $urandom_range(49) == 0 ? $urandom() : tick_now);
    endtask

    initial begin
        for (int i = 0; i < 8; i++) id_pool[i] = $urandom();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, duplicate ids, full table, unknown id, unused code.
        send_request(REQ_TICK, 32'd0, 32'd0, 32'd0);
        send_request(REQ_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_CREATE, 32'd0, 32'd0, 32'd0);
        send_request(REQ_COMPLETE, 32'hFFFF_FFFF, 32'd0, 32'd0);
        for (int i = 0; i < 17; i++)
            send_request(REQ_CREATE, 32'd7, 32'd1000 + 32'(i / 3), 32'd0);
        send_request(REQ_COMPLETE, 32'h1234_5678, 32'd0, 32'd0);
        send_request(2'd3, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd0);
        // Everything up to a deadline of 1005 expires at once; overdue store saturates.
        send_request(REQ_TICK, 32'd0, 32'd0, 32'd1005);
        write_period(10'd0);
        send_request(REQ_CREATE, 32'd3, 32'd0, 32'd50);
        send_request(REQ_TICK, 32'd0, 32'd0, 32'hFFFF_FFFF);
        write_period(10'h3FF);
        send_request(REQ_TICK, 32'd0, 32'd0, 32'hFFFF_FFFF);
        write_period(10'd1);
        tick_now = 32'd2000;

        // Random phases with different idling and period settings.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (phase == 3) write_period(10'd1000);
            else if (phase == 5) write_period(10'($urandom_range(1, 1000)));
            else if (phase == 7) write_period(10'd1);
            if (phase == 3 || phase == 5 || phase == 7) tick_now = $urandom_range(1000);
            for (int n = 0; n < 45; n++) begin
                send_random_request();
                if (n == 20 && phase == 2) drain_results();
            end
        end

        drain_results();
        if (scoreboard.mismatches == 0 && scoreboard.pending_events.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/edf_pkg.sv
rtl/edf_cell.sv
rtl/edf_row.sv
rtl/edf_deadline_task_table.sv
test/edf_deadline_task_table_tb.sv
